// File: rtl/core/bra_pkg.sv
// Shared types and constants for the region allocator.
package bra_pkg;

    localparam int unsigned ADDR_W = 48;
    localparam int unsigned SIZE_W = 41;
    localparam int unsigned STAT_W = 3;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 48;

    localparam int unsigned LIVE_ENTRIES_DEF = 256;
    localparam int unsigned FREE_ENTRIES_DEF = 256;
    localparam int unsigned GRANULE_BYTES_DEF = 512;

    localparam logic [SIZE_W-1:0] REGION_SIZE_RST = 41'd8589934592;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE = 1'b1;

    // Input kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_FRESH         = 3'd0,
        ST_REUSED        = 3'd1,
        ST_REFUSED       = 3'd2,
        ST_RELEASED      = 3'd3,
        ST_NOT_LIVE      = 3'd4,
        ST_OUTSIDE       = 3'd5,
        ST_RELEASED_LOST = 3'd6
    } status_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;        // capture input word, compute rounded size
        logic free_rd;     // read free table at scan index
        logic free_cmp;    // compare registered free entry
        logic shift_rd;    // read entry i+1 during compaction
        logic shift_wr;    // write entry i with registered data
        logic live_rd;     // read live table at scan index
        logic live_cmp;    // compare registered live entry
        logic idx_clr;     // clear scan index
        logic idx_inc;     // advance scan index
        logic grant_reuse; // finish allocate from free table
        logic grant_fresh; // finish allocate from bump cursor
        logic live_wr;     // write live slot
        logic free_push;   // append to free table, drop live entry
        logic drop_live;   // drop live entry only
        logic set_out;     // load output register
        status_t out_status;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic is_free;
        logic no_region;
        logic outside;
        logic live_full;
        logic free_hit;    // registered free entry size matches
        logic live_hit;    // matching live address found
        logic free_end;    // scan index reached free count
        logic shift_end;   // index+1 reached free count
        logic live_end;    // scan index at last live entry
        logic fresh_ok;
        logic free_full;
    } stat_t;

endpackage

// File: rtl/core/bra_ctrl.sv
// Sequencing state machine for the region allocator.
module bra_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    input  logic             out_busy,
    input  bra_pkg::stat_t   st,
    output logic             idle,
    output bra_pkg::cmd_t    cmd
);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b00000000001,
        S_DECIDE   = 11'b00000000010,
        S_FRD      = 11'b00000000100,
        S_FCMP     = 11'b00000001000,
        S_SRD      = 11'b00000010000,
        S_SWR      = 11'b00000100000,
        S_LRD      = 11'b00001000000,
        S_LCMP     = 11'b00010000000,
        S_FINISH   = 11'b00100000000,
        S_OUT      = 11'b01000000000,
        S_PICK     = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    bra_pkg::status_t res_reg, res_next;

    assign idle = (state_reg == S_IDLE);

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        cmd        = '0;
        cmd.out_status = res_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    cmd.idx_clr = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.idx_clr = 1'b1;
                if (st.is_free)
                begin
                    if (st.outside)
                    begin
                        res_next = bra_pkg::ST_OUTSIDE;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_LRD;
                    end
                end
                else if (st.no_region || st.live_full)
                begin
                    res_next = bra_pkg::ST_REFUSED;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_FRD;
                end
            end
            S_FRD:
            begin
                if (st.free_end)
                begin
                    state_next = S_PICK;
                end
                else
                begin
                    cmd.free_rd = 1'b1;
                    state_next = S_FCMP;
                end
            end
            S_FCMP:
            begin
                cmd.free_cmp = 1'b1;
                if (st.free_hit)
                begin
                    state_next = S_SRD;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next = S_FRD;
                end
            end
            S_SRD:
            begin
                if (st.shift_end)
                begin
                    cmd.grant_reuse = 1'b1;
                    res_next = bra_pkg::ST_REUSED;
                    cmd.idx_clr = 1'b1;
                    state_next = S_LRD;
                end
                else
                begin
                    cmd.shift_rd = 1'b1;
                    state_next = S_SWR;
                end
            end
            S_SWR:
            begin
                cmd.shift_wr = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next = S_SRD;
            end
            S_PICK:
            begin
                if (st.fresh_ok)
                begin
                    cmd.grant_fresh = 1'b1;
                    res_next = bra_pkg::ST_FRESH;
                    cmd.idx_clr = 1'b1;
                    state_next = S_LRD;
                end
                else
                begin
                    res_next = bra_pkg::ST_REFUSED;
                    state_next = S_OUT;
                end
            end
            S_LRD:
            begin
                cmd.live_rd = 1'b1;
                state_next = S_LCMP;
            end
            S_LCMP:
            begin
                cmd.live_cmp = 1'b1;
                if (st.live_hit || st.live_end)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next = S_LRD;
                end
            end
            S_FINISH:
            begin
                if (st.is_free)
                begin
                    if (!st.live_hit)
                    begin
                        res_next = bra_pkg::ST_NOT_LIVE;
                    end
                    else if (st.free_full)
                    begin
                        cmd.drop_live = 1'b1;
                        res_next = bra_pkg::ST_RELEASED_LOST;
                    end
                    else
                    begin
                        cmd.free_push = 1'b1;
                        res_next = bra_pkg::ST_RELEASED;
                    end
                end
                else
                begin
                    cmd.live_wr = 1'b1;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_busy)
                begin
                    cmd.set_out = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            res_reg   <= bra_pkg::ST_REFUSED;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    // One command of the table-writing kind at a time
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.live_wr, cmd.free_push, cmd.drop_live, cmd.shift_wr}) <= 1)
        else $error("multiple table writes");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == S_IDLE)
        else $error("load outside idle");
    a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.set_out |=> state_reg == S_IDLE)
        else $error("output not followed by idle");

endmodule

// File: rtl/core/bra_dp.sv
// Tables, bump cursor, scan index and result register of the region allocator.
module bra_dp
#(
    parameter int unsigned LIVE_ENTRIES  = bra_pkg::LIVE_ENTRIES_DEF,
    parameter int unsigned FREE_ENTRIES  = bra_pkg::FREE_ENTRIES_DEF,
    parameter int unsigned GRANULE_BYTES = bra_pkg::GRANULE_BYTES_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bra_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [bra_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          in_kind,
    input  logic [bra_pkg::ADDR_W-1:0]    in_req,
    input  logic [bra_pkg::ADDR_W-1:0]    in_addr,
    input  bra_pkg::cmd_t                 cmd,
    output bra_pkg::stat_t                st,
    input  logic                          out_take,
    output logic                          out_valid,
    output logic [bra_pkg::STAT_W-1:0]    out_status,
    output logic [bra_pkg::ADDR_W-1:0]    out_addr,
    output logic [bra_pkg::SIZE_W-1:0]    out_size
);

    localparam int unsigned AW = bra_pkg::ADDR_W;
    localparam int unsigned SW = bra_pkg::SIZE_W;
    localparam int unsigned LIW = (LIVE_ENTRIES > 1) ? $clog2(LIVE_ENTRIES) : 1;
    localparam int unsigned FIW = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
    localparam int unsigned FCW = $clog2(FREE_ENTRIES + 1);
    localparam int unsigned IXW = ((LIW > FIW) ? LIW : FIW) + 1;
    localparam int unsigned LCW = $clog2(LIVE_ENTRIES + 1);

    // Configuration registers
    logic [AW-1:0] base_reg;
    logic [SW-1:0] rsize_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            rsize_reg <= bra_pkg::REGION_SIZE_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_idx == bra_pkg::REG_BASE)
            begin
                base_reg <= cfg_data[AW-1:0];
            end
            else if (cfg_idx == bra_pkg::REG_SIZE)
            begin
                rsize_reg <= cfg_data[SW-1:0];
            end
        end
    end

    // Request capture; the granule is a power of two, so the remainder
    // is a mask and rounding is an add and a subtract
    logic          kind_reg;
    logic [AW-1:0] faddr_reg;
    logic [AW:0]   rnd_reg;      // rounded size, one extra bit for carry
    logic [AW-1:0] req1;
    logic [AW:0]   rnd_calc;
    logic [AW-1:0] rem_v;
    assign req1 = (in_req == '0) ? AW'(1) : in_req;
    always_comb
    begin
        rem_v = req1 & AW'(GRANULE_BYTES - 1);
        if (rem_v == '0)
        begin
            rnd_calc = {1'b0, req1};
        end
        else
        begin
            rnd_calc = {1'b0, req1} + (AW+1)'(GRANULE_BYTES) - {1'b0, rem_v};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= in_kind;
            faddr_reg <= in_addr;
            rnd_reg   <= rnd_calc;
        end
    end

    // Scan index and counters
    logic [IXW-1:0] idx_reg;
    logic [FCW-1:0] fcount_reg;
    logic [LCW-1:0] lcount_reg;
    logic [SW-1:0]  bump_reg;
    logic [AW-1:0]  grant_reg;
    logic           lhit_reg;
    logic [LIW-1:0] lslot_reg;
    logic           lempty_reg;

    // Tables
    logic [AW-1:0] live_addr_mem [LIVE_ENTRIES];
    logic [SW-1:0] live_size_mem [LIVE_ENTRIES];
    logic [LIVE_ENTRIES-1:0] live_valid_reg;
    logic [AW-1:0] free_addr_mem [FREE_ENTRIES];
    logic [SW-1:0] free_size_mem [FREE_ENTRIES];

    logic [AW-1:0] lrd_addr_reg;
    logic          lrd_valid_reg;
    logic [AW-1:0] frd_addr_reg;
    logic [SW-1:0] frd_size_reg;
    logic [SW-1:0] lsize_reg;

    logic [LIW-1:0] lidx;
    logic [FIW-1:0] fidx;
    logic [FIW-1:0] fidx1;
    logic [FIW-1:0] fpush;
    logic [AW-1:0]  key;
    assign lidx  = idx_reg[LIW-1:0];
    assign fidx  = idx_reg[FIW-1:0];
    assign fidx1 = FIW'(idx_reg + IXW'(1));
    assign fpush = fcount_reg[FIW-1:0];
    assign key   = kind_reg ? faddr_reg : grant_reg;

    // Free table memory
    always_ff @(posedge clk)
    begin
        if (cmd.free_rd)
        begin
            frd_addr_reg <= free_addr_mem[fidx];
            frd_size_reg <= free_size_mem[fidx];
        end
        else if (cmd.shift_rd)
        begin
            frd_addr_reg <= free_addr_mem[fidx1];
            frd_size_reg <= free_size_mem[fidx1];
        end
        if (cmd.shift_wr)
        begin
            free_addr_mem[fidx] <= frd_addr_reg;
            free_size_mem[fidx] <= frd_size_reg;
        end
        else if (cmd.free_push)
        begin
            free_addr_mem[fpush] <= faddr_reg;
            free_size_mem[fpush] <= lsize_reg;
        end
    end

    // Live table memory
    always_ff @(posedge clk)
    begin
        if (cmd.live_rd)
        begin
            lrd_addr_reg <= live_addr_mem[lidx];
            lsize_reg    <= live_size_mem[lidx];
        end
        if (cmd.live_wr)
        begin
            live_addr_mem[lslot_reg] <= grant_reg;
            live_size_mem[lslot_reg] <= rnd_reg[SW-1:0];
        end
    end

    // Fresh fit check
    logic [AW+1:0] end_sum;
    logic          fresh_ok;
    assign end_sum = {2'b0, base_reg} + (AW+2)'(bump_reg) + {1'b0, rnd_reg};
    assign fresh_ok = (rnd_reg <= (AW+1)'(rsize_reg)) &&
                      (bump_reg <= rsize_reg - rnd_reg[SW-1:0]) &&
                      (end_sum <= ((AW+2)'(1) << AW));

    // Control and status registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            fcount_reg     <= '0;
            lcount_reg     <= '0;
            bump_reg       <= '0;
            live_valid_reg <= '0;
            lhit_reg       <= 1'b0;
            lempty_reg     <= 1'b0;
            lrd_valid_reg  <= 1'b0;
            lslot_reg      <= '0;
            grant_reg      <= '0;
        end
        else
        begin
            if (cmd.idx_clr)
            begin
                idx_reg    <= '0;
                lhit_reg   <= 1'b0;
                lempty_reg <= 1'b0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + IXW'(1);
            end
            if (cmd.live_rd)
            begin
                lrd_valid_reg <= live_valid_reg[lidx];
            end
            if (cmd.free_cmp)
            begin
                grant_reg <= frd_addr_reg;
            end
            // live scan: first match wins, else first empty slot
            if (cmd.live_cmp)
            begin
                if (lrd_valid_reg && lrd_addr_reg == key)
                begin
                    lhit_reg  <= 1'b1;
                    lslot_reg <= lidx;
                end
                else if (!lrd_valid_reg && !lempty_reg)
                begin
                    lempty_reg <= 1'b1;
                    if (!kind_reg)
                    begin
                        lslot_reg <= lidx;
                    end
                end
            end
            if (cmd.grant_reuse)
            begin
                fcount_reg <= fcount_reg - FCW'(1);
            end
            if (cmd.grant_fresh)
            begin
                grant_reg <= base_reg + AW'(bump_reg);
                bump_reg  <= bump_reg + rnd_reg[SW-1:0];
            end
            if (cmd.live_wr)
            begin
                if (!live_valid_reg[lslot_reg])
                begin
                    lcount_reg <= lcount_reg + LCW'(1);
                end
                live_valid_reg[lslot_reg] <= 1'b1;
            end
            if (cmd.free_push || cmd.drop_live)
            begin
                live_valid_reg[lslot_reg] <= 1'b0;
                lcount_reg <= lcount_reg - LCW'(1);
            end
            if (cmd.free_push)
            begin
                fcount_reg <= fcount_reg + FCW'(1);
            end
        end
    end

    // Status to controller
    logic [AW:0] region_end;
    assign region_end = {1'b0, base_reg} + (AW+1)'(rsize_reg);
    always_comb
    begin
        st.is_free   = kind_reg;
        st.no_region = (base_reg == '0);
        st.outside   = (base_reg == '0) || (faddr_reg < base_reg) ||
                       ({1'b0, faddr_reg} >= region_end);
        st.live_full = (lcount_reg == LCW'(LIVE_ENTRIES));
        st.free_hit  = ((AW+1)'(frd_size_reg) == rnd_reg);
        st.live_hit  = lhit_reg ||
                       (cmd.live_cmp && lrd_valid_reg && lrd_addr_reg == key);
        st.free_end  = (idx_reg >= IXW'(fcount_reg));
        st.shift_end = ((idx_reg + IXW'(1)) >= IXW'(fcount_reg));
        st.live_end  = (idx_reg == IXW'(LIVE_ENTRIES - 1));
        st.fresh_ok  = fresh_ok;
        st.free_full = (fcount_reg == FCW'(FREE_ENTRIES));
    end

    // lsize for free path: the size read with the matching entry
    // stays put because the scan stops on a hit.

    // Output register
    logic [bra_pkg::STAT_W-1:0] ost_reg;
    logic [AW-1:0] oaddr_reg;
    logic [SW-1:0] osize_reg;
    logic          ovalid_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (cmd.set_out)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.set_out)
        begin
            ost_reg <= cmd.out_status;
            case (cmd.out_status)
                bra_pkg::ST_FRESH, bra_pkg::ST_REUSED:
                begin
                    oaddr_reg <= grant_reg;
                    osize_reg <= rnd_reg[SW-1:0];
                end
                bra_pkg::ST_RELEASED, bra_pkg::ST_RELEASED_LOST:
                begin
                    oaddr_reg <= '0;
                    osize_reg <= lsize_reg;
                end
                default:
                begin
                    oaddr_reg <= '0;
                    osize_reg <= '0;
                end
            endcase
        end
    end

    assign out_valid  = ovalid_reg;
    assign out_status = ost_reg;
    assign out_addr   = oaddr_reg;
    assign out_size   = osize_reg;

    a_fcount: assert property (@(posedge clk) disable iff (!rst_n)
        fcount_reg <= FCW'(FREE_ENTRIES))
        else $error("free count overflow");
    a_lcount: assert property (@(posedge clk) disable iff (!rst_n)
        lcount_reg == LCW'($countones(live_valid_reg)))
        else $error("live count mismatch");
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.free_push |-> fcount_reg < FCW'(FREE_ENTRIES))
        else $error("push into full free table");

endmodule

// File: rtl/core/bump_region_allocator_with_free_list.sv
// Region allocator: bump cursor with an exact-size free table, one word at a time.
// Each word is processed alone; the input is ready only while the block is idle and
// the result register may still hold an unread result. An allocate scans the free
// table for an entry of the exact rounded size; on a match it moves the later entries
// up and takes that entry, else it takes space from the bump cursor if it fits. It
// then scans the live table for a slot. A free scans the live table for its address.
// An allocate refused up front or a free outside the region goes straight to the
// result. A result held back by the receiver stalls the block before its next result
// is written. The table memories are read one entry at a time; each entry is read in
// one state and compared in another. GRANULE_BYTES must be a power of two.
// No clearing pass is needed.
module bump_region_allocator_with_free_list
#(
    parameter int unsigned LIVE_ENTRIES  = bra_pkg::LIVE_ENTRIES_DEF,
    parameter int unsigned FREE_ENTRIES  = bra_pkg::FREE_ENTRIES_DEF,
    parameter int unsigned GRANULE_BYTES = bra_pkg::GRANULE_BYTES_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [bra_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bra_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [0:0]    s_tuser,   // kind
    input  logic [95:0]   s_tdata,   // request_size[47:0], free_address[95:48]
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [95:0]   m_tdata    // status[2:0], block_address[50:3], block_size[91:51]
);

    bra_pkg::cmd_t  cmd;
    bra_pkg::stat_t st;
    logic idle;
    logic in_fire;
    logic [bra_pkg::STAT_W-1:0] o_status;
    logic [bra_pkg::ADDR_W-1:0] o_addr;
    logic [bra_pkg::SIZE_W-1:0] o_size;

    assign s_tready = idle;
    assign in_fire  = s_tvalid && s_tready;

    bra_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_busy (m_tvalid && !m_tready),
        .st       (st),
        .idle     (idle),
        .cmd      (cmd)
    );

    bra_dp
    #(
        .LIVE_ENTRIES  (LIVE_ENTRIES),
        .FREE_ENTRIES  (FREE_ENTRIES),
        .GRANULE_BYTES (GRANULE_BYTES)
    )
    u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_index),
        .cfg_data   (cfg_data),
        .in_kind    (s_tuser[0]),
        .in_req     (s_tdata[47:0]),
        .in_addr    (s_tdata[95:48]),
        .cmd        (cmd),
        .st         (st),
        .out_take   (m_tready),
        .out_valid  (m_tvalid),
        .out_status (o_status),
        .out_addr   (o_addr),
        .out_size   (o_size)
    );

    assign m_tdata = {4'b0, o_size, o_addr, o_status};

endmodule
